>>> rtl/bhwc_pkg.sv
// ----------------------------------------------------------------------------
// bhwc_pkg
// Types, register indexes and constants of the boiler hot water controller.
// ----------------------------------------------------------------------------
package bhwc_pkg;

  localparam int TempW   = 12;
  localparam int OffsetW = 11;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 12;
  localparam int CalcW   = 28;

  typedef logic signed [TempW-1:0]   temp_t;
  typedef logic        [OffsetW-1:0] offset_t;
  typedef logic signed [CalcW-1:0]   calc_t;

  typedef enum logic [1:0] {
    MODE_INIT    = 2'd0,
    MODE_IDLE    = 2'd1,
    MODE_FURNACE = 2'd2,
    MODE_STORAGE = 2'd3
  } mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SYSTEM_ENABLE      = 3'd0,
    REG_CIRCULATION_ENABLE = 3'd1,
    REG_CURVE_AT_PLUS15    = 3'd2,
    REG_CURVE_AT_MINUS15   = 3'd3,
    REG_FURNACE_MAX_OFFSET = 3'd4,
    REG_DHW_MIN_TEMP       = 3'd5,
    REG_DHW_MAX_TEMP       = 3'd6,
    REG_UNUSED             = 3'd7
  } reg_idx_t;

  // temperatures in 1/16 degC
  localparam temp_t   RstCurvePlus15  = 12'sd640;
  localparam temp_t   RstCurveMinus15 = 12'sd1120;
  localparam offset_t RstFurnaceOff   = 11'd160;
  localparam temp_t   RstDhwMin       = 12'sd640;
  localparam temp_t   RstDhwMax       = 12'sd880;

  localparam temp_t OvertempLimit = 12'sd1520;
  localparam calc_t CurveScale    = 28'sd480;
  localparam calc_t CurveMid      = 28'sd240;
  localparam calc_t TargetCap     = 28'sd691200;  // 90 degC times 480
  localparam calc_t HoldMargin    = 28'sd80;      // 5 degC
  localparam logic signed [12:0] PumpBand = 13'sd16;  // 1 degC

endpackage

>>> rtl/boiler_hot_water_controller.sv
// Path: each tick passes through the input register, then the result
// register.
// Throughput: one item per cycle while out_stall does not hold the output; the
// target multiplies sit between the input register and the state/result registers.
// Reset: synchronous, active low; control state to init, relays off, fault
// cleared, configuration registers back to their defaults.
// ----------------------------------------------------------------------------
// boiler_hot_water_controller
// Weather compensated furnace and hot water controller, one control tick per
// transaction, with hysteresis on heater and storage pump and a latched overtemp fault.
// ----------------------------------------------------------------------------
module boiler_hot_water_controller (
  input  logic                 clk,
  input  logic                 rst_n,
  // control ticks
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bhwc_pkg::temp_t      in_outside_temp,
  input  bhwc_pkg::temp_t      in_furnace_temp,
  input  bhwc_pkg::temp_t      in_storage_temp,
  input  logic                 in_sensors_valid,
  // relay commands
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_heater_on,
  output logic                 out_storage_pump_on,
  output logic                 out_circulation_pump_on,
  output logic [1:0]           out_control_state,
  output logic                 out_running,
  output logic                 out_overtemp_fault,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  bhwc_pkg::reg_idx_t   cfg_index,
  input  logic [bhwc_pkg::CfgDatW-1:0] cfg_data
);
  import bhwc_pkg::*;

  // configuration
  logic    sys_en_r, circ_en_r;
  temp_t   curve_p15_r, curve_m15_r, dhw_min_r, dhw_max_r;
  offset_t furnace_off_r;

  // input register
  logic  s1_valid_r;
  temp_t s1_outside_r, s1_furnace_r, s1_storage_r;
  logic  s1_sens_ok_r;

  // control state, also the result payload
  mode_t mode_r, mode_nxt;
  logic  heater_hold_r, heater_hold_nxt;
  logic  heater_r, heater_nxt;
  logic  spump_r, spump_nxt;
  logic  circ_r, circ_nxt;
  logic  running_r, running_nxt;
  logic  fault_r, fault_nxt;
  logic  out_valid_r;

  logic advance, fire;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid_r || !out_stall;
  assign fire      = s1_valid_r && advance;
  assign in_stall  = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sys_en_r      <= 1'b0;
      circ_en_r     <= 1'b0;
      curve_p15_r   <= RstCurvePlus15;
      curve_m15_r   <= RstCurveMinus15;
      furnace_off_r <= RstFurnaceOff;
      dhw_min_r     <= RstDhwMin;
      dhw_max_r     <= RstDhwMax;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SYSTEM_ENABLE:      sys_en_r      <= cfg_data[0];
        REG_CIRCULATION_ENABLE: circ_en_r     <= cfg_data[0];
        REG_CURVE_AT_PLUS15:    curve_p15_r   <= temp_t'(cfg_data);
        REG_CURVE_AT_MINUS15:   curve_m15_r   <= temp_t'(cfg_data);
        REG_FURNACE_MAX_OFFSET: furnace_off_r <= cfg_data[OffsetW-1:0];
        REG_DHW_MIN_TEMP:       dhw_min_r     <= temp_t'(cfg_data);
        REG_DHW_MAX_TEMP:       dhw_max_r     <= temp_t'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_outside_r <= in_outside_temp;
      s1_furnace_r <= in_furnace_temp;
      s1_storage_r <= in_storage_temp;
      s1_sens_ok_r <= in_sensors_valid;
    end
  end

  // target times 480: 480*N + (O+240)*(P-N), capped at 90 degC
  logic signed [12:0] o_mid, p_minus_n, f_minus_s;
  logic signed [25:0] slope_prod;
  calc_t t_raw, target, f480, off480, dmax480, hold_on_lim, hold_off_lim;

  always_comb begin
    o_mid       = 13'(s1_outside_r) + 13'(CurveMid);
    p_minus_n   = 13'(curve_p15_r) - 13'(curve_m15_r);
    slope_prod  = 26'(o_mid) * 26'(p_minus_n);
    t_raw       = calc_t'(curve_m15_r) * CurveScale + calc_t'(slope_prod);
    target      = (t_raw < TargetCap) ? t_raw : TargetCap;
    f480        = calc_t'(s1_furnace_r) * CurveScale;
    off480      = calc_t'($signed({1'b0, furnace_off_r})) * CurveScale;
    dmax480     = calc_t'(dhw_max_r) * CurveScale;
    hold_off_lim = (calc_t'(dhw_max_r) + HoldMargin) * CurveScale;
    if (target > hold_off_lim) hold_off_lim = target;
    hold_on_lim = target - off480;
    if (dmax480 > hold_on_lim) hold_on_lim = dmax480;
    f_minus_s   = 13'(s1_furnace_r) - 13'(s1_storage_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_INIT;
      heater_hold_r <= 1'b0;
      heater_r      <= 1'b0;
      spump_r       <= 1'b0;
      circ_r        <= 1'b0;
      running_r     <= 1'b0;
      fault_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (fire) begin
        mode_r        <= mode_nxt;
        heater_hold_r <= heater_hold_nxt;
        heater_r      <= heater_nxt;
        spump_r       <= spump_nxt;
        circ_r        <= circ_nxt;
        running_r     <= running_nxt;
        fault_r       <= fault_nxt;
      end
    end
  end

  always_comb begin
    mode_nxt        = mode_r;
    heater_hold_nxt = heater_hold_r;
    heater_nxt      = heater_r;
    spump_nxt       = spump_r;
    circ_nxt        = circ_r;
    running_nxt     = running_r;
    fault_nxt       = fault_r;
    if (!fault_r) begin
      if (!sys_en_r || !s1_sens_ok_r || dhw_min_r >= dhw_max_r) begin
        mode_nxt    = MODE_INIT;
        running_nxt = 1'b0;
        heater_nxt  = 1'b0;
        spump_nxt   = 1'b0;
        circ_nxt    = 1'b0;
      end else if (s1_outside_r > OvertempLimit || s1_furnace_r > OvertempLimit ||
                   s1_storage_r > OvertempLimit) begin
        fault_nxt   = 1'b1;
        mode_nxt    = MODE_INIT;
        running_nxt = 1'b0;
        heater_nxt  = 1'b0;
        spump_nxt   = 1'b0;
        circ_nxt    = 1'b0;
      end else begin
        heater_nxt = 1'b0;
        spump_nxt  = 1'b0;
        circ_nxt   = 1'b0;
        unique case (mode_r)
          MODE_INIT: begin
            running_nxt = 1'b1;
            mode_nxt    = MODE_IDLE;
          end
          MODE_IDLE: begin
            circ_nxt = circ_en_r;
            if (s1_storage_r < dhw_min_r) begin
              heater_hold_nxt = s1_furnace_r < dhw_max_r;
              spump_nxt       = s1_furnace_r > s1_storage_r;
              mode_nxt        = MODE_STORAGE;
            end else if (f480 < target - off480) begin
              mode_nxt = MODE_FURNACE;
            end
          end
          MODE_FURNACE: begin
            heater_nxt = 1'b1;
            circ_nxt   = circ_en_r;
            if (f480 >= target) mode_nxt = MODE_IDLE;
          end
          default: begin
            if (s1_storage_r >= dhw_max_r) begin
              mode_nxt = MODE_IDLE;
            end else begin
              if (heater_hold_r) begin
                if (f480 >= hold_off_lim) heater_hold_nxt = 1'b0;
              end else begin
                if (f480 < hold_on_lim) heater_hold_nxt = 1'b1;
              end
              heater_nxt = heater_hold_nxt;
              // pump holds its state inside the 1 degC band
              if (f_minus_s > -PumpBand && f_minus_s < PumpBand) begin
                spump_nxt = spump_r;
              end else begin
                spump_nxt = f_minus_s >= PumpBand;
              end
            end
          end
        endcase
      end
    end
  end

  assign out_valid               = out_valid_r;
  assign out_heater_on           = heater_r;
  assign out_storage_pump_on     = spump_r;
  assign out_circulation_pump_on = circ_r;
  assign out_control_state       = mode_r;
  assign out_running             = running_r;
  assign out_overtemp_fault      = fault_r;

`ifndef SYNTHESIS
  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fault_r |=> fault_r)
    else $error("overtemp fault cleared without reset");

  a_fault_safe: assert property (@(posedge clk) disable iff (!rst_n)
    fault_r |-> (!heater_r && !spump_r && !circ_r && mode_r == MODE_INIT && !running_r))
    else $error("relays active with overtemp fault latched");

  a_init_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> (!heater_r && !spump_r && !circ_r && mode_r == MODE_INIT))
    else $error("relays or state active while not running");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked transaction");
`endif

endmodule
